### rtl/core/dtcw_pkg.sv
// Package for the date and time check block: shared constants, types and
// calendar lookup functions. Used by every module under rtl/core.
// No dependencies.
package dtcw_pkg;

  // Field widths of the request and result ports.
  localparam int unsigned SmallW = 7;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned SpanW  = 7;

  // Accepted ranges.
  localparam logic [SmallW-1:0] HourLimit = 7'd24;
  localparam logic [SmallW-1:0] MinLimit  = 7'd60;
  localparam logic [YearW-1:0]  FirstYear = 14'd2007;
  localparam logic [YearW-1:0]  LastYear  = 14'd2099;
  localparam logic [DoyW-1:0]   MaxDoy    = 9'd366;
  localparam logic [WdayW-1:0]  MaxWday   = 3'd6;

  // Month numbers that need a special case.
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  // Check result handed from the check stage to the weekday logic.
  typedef struct packed {
    logic             ok;
    logic [DoyW-1:0]  doy;
    logic [SpanW-1:0] span;
  } dtcw_chk_t;

  // Days in a common year before the first of the given month.
  function automatic logic [DoyW-1:0] days_before(input logic [3:0] month);
    logic [DoyW-1:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of the given month in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] l;
    case (month)
      4'd2:    l = 5'd28;
      4'd4:    l = 5'd30;
      4'd6:    l = 5'd30;
      4'd9:    l = 5'd30;
      4'd11:   l = 5'd30;
      4'd1:    l = 5'd31;
      4'd3:    l = 5'd31;
      4'd5:    l = 5'd31;
      4'd7:    l = 5'd31;
      4'd8:    l = 5'd31;
      4'd10:   l = 5'd31;
      4'd12:   l = 5'd31;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

  // Remainder by seven: since 8 is 1 mod 7, octal digits are summed twice
  // and one final subtract settles the value.
  function automatic logic [WdayW-1:0] mod7(input logic [DoyW-1:0] x);
    logic [4:0] f1;
    logic [3:0] f2;
    f1 = {2'b00, x[8:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
    f2 = {2'b00, f1[4:3]} + {1'b0, f1[2:0]};
    if (f2 >= 4'd7) begin
      f2 = f2 - 4'd7;
    end
    return f2[2:0];
  endfunction

endpackage

### rtl/core/dtcw_check.sv
// Range check of all time and date fields plus the day of year.
// Depends on dtcw_pkg.
module dtcw_check (
  input  logic [dtcw_pkg::SmallW-1:0] hour_i,
  input  logic [dtcw_pkg::SmallW-1:0] minute_i,
  input  logic [dtcw_pkg::SmallW-1:0] second_i,
  input  logic [dtcw_pkg::YearW-1:0]  year_i,
  input  logic [dtcw_pkg::SmallW-1:0] month_i,
  input  logic [dtcw_pkg::SmallW-1:0] day_i,
  output dtcw_pkg::dtcw_chk_t         chk_o
);

  logic                        leap;
  logic [3:0]                  mon;
  logic [4:0]                  mlen;
  logic                        time_ok;
  logic                        year_ok;
  logic                        month_ok;
  logic                        day_ok;
  logic [dtcw_pkg::YearW-1:0]  span_full;

  // Leap years in the allowed span are exactly the multiples of four.
  assign leap = (year_i[1:0] == 2'b00);
  assign mon  = month_i[3:0];

  // Field range checks.
  always_comb begin
    time_ok  = (hour_i < dtcw_pkg::HourLimit) && (minute_i < dtcw_pkg::MinLimit) &&
               (second_i < dtcw_pkg::MinLimit);
    year_ok  = year_i inside {[dtcw_pkg::FirstYear:dtcw_pkg::LastYear]};
    month_ok = month_i inside {[7'd1:7'd12]};
    mlen     = dtcw_pkg::month_len(mon);
    if ((mon == dtcw_pkg::MonthFeb) && leap) begin
      mlen = 5'd29;
    end
    day_ok   = (day_i != 7'd0) && (day_i <= {2'b00, mlen});
  end

  // Day of year and year offset; only meaningful when the check passes.
  always_comb begin
    span_full  = year_i - dtcw_pkg::FirstYear;
    chk_o.ok   = time_ok && year_ok && month_ok && day_ok;
    chk_o.span = span_full[dtcw_pkg::SpanW-1:0];
    chk_o.doy  = dtcw_pkg::days_before(mon) + {2'b00, day_i} +
                 {8'd0, (leap && (mon > dtcw_pkg::MonthFeb))};
  end

endmodule

### rtl/core/dtcw_weekday.sv
// Weekday from the year offset and day of year, Monday 1 January 2007 = 0.
// Depends on dtcw_pkg.
module dtcw_weekday (
  input  dtcw_pkg::dtcw_chk_t         chk_i,
  output logic [dtcw_pkg::WdayW-1:0]  weekday_o
);

  logic [dtcw_pkg::SpanW-1:0] leap_full;
  logic [4:0]                 leap_cnt;
  logic [dtcw_pkg::DoyW-1:0]  days;

  // A common year shifts the weekday by one; leap days since 2007 are
  // (span + 2) / 4 because 2006 leaves a remainder of two.
  always_comb begin
    leap_full = (chk_i.span + 7'd2) >> 2;
    leap_cnt  = leap_full[4:0];
    days      = {2'b00, chk_i.span} + {4'd0, leap_cnt} + chk_i.doy - 9'd1;
    weekday_o = dtcw_pkg::mod7(days);
  end

endmodule

### rtl/core/date_time_check_and_weekday.sv
// Top level of the date and time check: request register, check and weekday
// logic, result register. Depends on dtcw_pkg, dtcw_check and dtcw_weekday.
//
// Usage:
//   A request is taken at a rising clock edge where start_i is high and
//   busy_o is low. busy_o stays low, so one request may be issued every cycle.
//   Each request yields exactly one result, shown for one cycle with done_o
//   high: status_o is 0 when all fields are in range, and then day_of_year_o
//   (1..366) and weekday_o (0 Monday .. 6 Sunday) are valid; otherwise
//   status_o is 1 and both are 0.
//   The request is registered, then the check, day of year and weekday logic
//   feeds the result register. Throughput is one request per cycle; the path
//   between the two registers is a table lookup, a 9-bit add chain and a
//   mod-7 fold.
//   The receiver has no way to hold results off; each result is present for
//   exactly the one cycle it is strobed.
//   Reset clears the request and result strobes, so no result appears until
//   a request has been taken after reset.
module date_time_check_and_weekday (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [dtcw_pkg::SmallW-1:0] hour_i,
  input  logic [dtcw_pkg::SmallW-1:0] minute_i,
  input  logic [dtcw_pkg::SmallW-1:0] second_i,
  input  logic [dtcw_pkg::YearW-1:0]  year_i,
  input  logic [dtcw_pkg::SmallW-1:0] month_i,
  input  logic [dtcw_pkg::SmallW-1:0] day_i,
  output logic                        done_o,
  output logic                        status_o,
  output logic [dtcw_pkg::DoyW-1:0]   day_of_year_o,
  output logic [dtcw_pkg::WdayW-1:0]  weekday_o
);

  logic                        req_valid_q;
  logic [dtcw_pkg::SmallW-1:0] hour_q;
  logic [dtcw_pkg::SmallW-1:0] minute_q;
  logic [dtcw_pkg::SmallW-1:0] second_q;
  logic [dtcw_pkg::YearW-1:0]  year_q;
  logic [dtcw_pkg::SmallW-1:0] month_q;
  logic [dtcw_pkg::SmallW-1:0] day_q;

  dtcw_pkg::dtcw_chk_t         chk;
  logic [dtcw_pkg::WdayW-1:0]  wday;

  logic                        done_q;
  logic                        status_q;
  logic                        status_d;
  logic [dtcw_pkg::DoyW-1:0]   doy_q;
  logic [dtcw_pkg::DoyW-1:0]   doy_d;
  logic [dtcw_pkg::WdayW-1:0]  wday_q;
  logic [dtcw_pkg::WdayW-1:0]  wday_d;
  logic                        accept;

  // The pipeline never stalls, so a request is always taken.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Strobes of the request and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= accept;
      done_q      <= req_valid_q;
    end
  end

  // Request payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hour_q   <= hour_i;
      minute_q <= minute_i;
      second_q <= second_i;
      year_q   <= year_i;
      month_q  <= month_i;
      day_q    <= day_i;
    end
  end

  dtcw_check u_check (
    .hour_i   (hour_q),
    .minute_i (minute_q),
    .second_i (second_q),
    .year_i   (year_q),
    .month_i  (month_q),
    .day_i    (day_q),
    .chk_o    (chk)
  );

  dtcw_weekday u_weekday (
    .chk_i     (chk),
    .weekday_o (wday)
  );

  // Failed requests report zero for both result values.
  always_comb begin
    status_d = !chk.ok;
    doy_d    = chk.ok ? chk.doy : '0;
    wday_d   = chk.ok ? wday : '0;
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      status_q <= status_d;
      doy_q    <= doy_d;
      wday_q   <= wday_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign day_of_year_o = doy_q;
  assign weekday_o     = wday_q;

  // Every accepted request produces a result through the request and result registers.
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted request produced no result");

  // No result without a request held in the request register.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_valid_q))
    else $error("result strobe without request");

  // A passing date has a day of year in 1..366 and a weekday in 0..6.
  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !status_o) |-> ((day_of_year_o != '0) &&
      (day_of_year_o <= dtcw_pkg::MaxDoy) && (weekday_o <= dtcw_pkg::MaxWday)))
    else $error("valid result out of range");

  // A failing date reports zero values.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> ((day_of_year_o == '0) && (weekday_o == '0)))
    else $error("failed result carries nonzero values");

endmodule

### sim/tb_date_time_check_and_weekday.sv
// Testbench for date_time_check_and_weekday: sends date and time requests,
// predicts the validity flag, day of year and weekday, and compares each result.
// Depends on dtcw_pkg and the RTL top level; reads no files.
module tb_date_time_check_and_weekday;

  localparam int unsigned SmallW = dtcw_pkg::SmallW;
  localparam int unsigned YearW  = dtcw_pkg::YearW;
  localparam int unsigned DoyW   = dtcw_pkg::DoyW;
  localparam int unsigned WdayW  = dtcw_pkg::WdayW;

  localparam logic StatusValid   = 1'b0;
  localparam logic StatusInvalid = 1'b1;
  localparam int unsigned NumRandom  = 600;
  localparam int unsigned StallLimit = 500;
  localparam int unsigned DrainCycles = 8;

  // One request as presented on the input ports.
  typedef struct packed {
    logic [SmallW-1:0] hour;
    logic [SmallW-1:0] minute;
    logic [SmallW-1:0] second;
    logic [YearW-1:0]  year;
    logic [SmallW-1:0] month;
    logic [SmallW-1:0] day;
  } date_req_t;

  // One result as seen on the output ports.
  typedef struct packed {
    logic             status;
    logic [DoyW-1:0]  doy;
    logic [WdayW-1:0] wday;
  } date_res_t;

  // Calendar predictor and the queue of results still to come.
  class date_result_board;
    date_res_t   expected_dates[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Length of a month in a given year; leap years are those divisible by 4.
    static function int unsigned month_days(int unsigned month, int unsigned year);
      int unsigned len;
      case (month)
        dtcw_pkg::MonthFeb: len = (year % 4 == 0) ? 29 : 28;
        4, 6, 9, 11:        len = 30;
        default:            len = 31;
      endcase
      return len;
    endfunction

    // Works out the result for one request.
    function date_res_t calendar_predict(date_req_t r);
      date_res_t   res;
      bit          ok;
      int unsigned doy;
      int unsigned elapsed;
      ok = (r.hour < dtcw_pkg::HourLimit) && (r.minute < dtcw_pkg::MinLimit)
           && (r.second < dtcw_pkg::MinLimit)
           && (r.year >= dtcw_pkg::FirstYear) && (r.year <= dtcw_pkg::LastYear)
           && (r.month >= 1) && (r.month <= 12);
      if (ok) begin
        ok = (r.day >= 1) && (r.day <= month_days(r.month, r.year));
      end
      res = '0;
      res.status = StatusInvalid;
      if (ok) begin
        doy = r.day;
        for (int unsigned m = 1; m < r.month; m++) begin
          doy += month_days(m, r.year);
        end
        // Whole days from Monday 1 January 2007 to 1 January of this year.
        elapsed = 365 * (r.year - dtcw_pkg::FirstYear) + (r.year - 1) / 4
                  - (dtcw_pkg::FirstYear - 1) / 4;
        res.status = StatusValid;
        res.doy    = doy[DoyW-1:0];
        res.wday   = WdayW'((elapsed + doy - 1) % 7);
      end
      return res;
    endfunction

    function void note_request(date_req_t r);
      expected_dates.push_back(calendar_predict(r));
    endfunction

    function void check_result(date_res_t got);
      date_res_t want;
      if (expected_dates.size() == 0) begin
        $error("unexpected result: status %0d day_of_year %0d weekday %0d",
               got.status, got.doy, got.wday);
        errors++;
        return;
      end
      want = expected_dates.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.doy !== want.doy) begin
        $error("day_of_year: expected %0d, actual %0d", want.doy, got.doy);
        errors++;
      end
      if (got.wday !== want.wday) begin
        $error("weekday: expected %0d, actual %0d", want.wday, got.wday);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [SmallW-1:0]   hour_i;
  logic [SmallW-1:0]   minute_i;
  logic [SmallW-1:0]   second_i;
  logic [YearW-1:0]    year_i;
  logic [SmallW-1:0]   month_i;
  logic [SmallW-1:0]   day_i;
  logic                done_o;
  logic                status_o;
  logic [DoyW-1:0]     day_of_year_o;
  logic [WdayW-1:0]    weekday_o;

  date_result_board dates = new();
  int unsigned      stall_cycles = 0;

  date_time_check_and_weekday DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .second_i      (second_i),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .day_of_year_o (day_of_year_o),
    .weekday_o     (weekday_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      dates.check_result('{status: status_o, doy: day_of_year_o, wday: weekday_o});
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb_date_time_check_and_weekday NOT OK");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input date_req_t r);
    hour_i   <= r.hour;
    minute_i <= r.minute;
    second_i <= r.second;
    year_i   <= r.year;
    month_i  <= r.month;
    day_i    <= r.day;
    start_i  <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    dates.note_request(r);
  endtask

  // Drops start for the given number of cycles with junk on the fields.
  task automatic idle_gap(input int unsigned cycles);
    start_i  <= 1'b0;
    hour_i   <= SmallW'($urandom);
    minute_i <= SmallW'($urandom);
    second_i <= SmallW'($urandom);
    year_i   <= YearW'($urandom);
    month_i  <= SmallW'($urandom);
    day_i    <= SmallW'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic date_req_t make_date(int unsigned y, int unsigned mo, int unsigned d,
                                          int unsigned h, int unsigned mi, int unsigned s);
    date_req_t r;
    r.hour   = SmallW'(h);
    r.minute = SmallW'(mi);
    r.second = SmallW'(s);
    r.year   = YearW'(y);
    r.month  = SmallW'(mo);
    r.day    = SmallW'(d);
    return r;
  endfunction

  // A well-formed request with random content.
  function automatic date_req_t random_valid_date();
    int unsigned y;
    int unsigned mo;
    y  = $urandom_range(dtcw_pkg::LastYear, dtcw_pkg::FirstYear);
    mo = $urandom_range(12, 1);
    return make_date(y, mo, $urandom_range(date_result_board::month_days(mo, y), 1),
                     $urandom_range(23, 0), $urandom_range(59, 0), $urandom_range(59, 0));
  endfunction

  // A well-formed request with exactly one field pushed out of range.
  function automatic date_req_t random_broken_date();
    date_req_t r;
    r = random_valid_date();
    case ($urandom_range(5, 0))
      0: r.hour   = SmallW'($urandom_range(127, 24));
      1: r.minute = SmallW'($urandom_range(127, 60));
      2: r.second = SmallW'($urandom_range(127, 60));
      3: r.year   = $urandom_range(1, 0) ? YearW'($urandom_range(2006, 0))
                                         : YearW'($urandom_range(16383, 2100));
      4: r.month  = $urandom_range(1, 0) ? SmallW'(0) : SmallW'($urandom_range(127, 13));
      default: begin
        r.day = $urandom_range(1, 0) ? SmallW'(0)
              : SmallW'($urandom_range(127,
                  date_result_board::month_days(r.month, r.year) + 1));
      end
    endcase
    return r;
  endfunction

  initial begin
    date_req_t r;
    int unsigned pick;
    rst_ni   <= 1'b0;
    start_i  <= 1'b0;
    hour_i   <= '0;
    minute_i <= '0;
    second_i <= '0;
    year_i   <= '0;
    month_i  <= '0;
    day_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range edges, leap February, the 30-day months and all-ones fields.
    send_request(make_date(2007, 1, 1, 0, 0, 0));
    send_request(make_date(2099, 12, 31, 23, 59, 59));
    send_request(make_date(2008, 12, 31, 12, 30, 30));
    send_request(make_date(2008, 2, 29, 1, 2, 3));
    send_request(make_date(2007, 2, 29, 1, 2, 3));
    send_request(make_date(2008, 2, 30, 1, 2, 3));
    send_request(make_date(2007, 2, 28, 1, 2, 3));
    send_request(make_date(2010, 6, 30, 8, 0, 0));
    send_request(make_date(2010, 6, 31, 8, 0, 0));
    send_request(make_date(2010, 4, 31, 8, 0, 0));
    send_request(make_date(2010, 9, 30, 8, 0, 0));
    send_request(make_date(2010, 11, 31, 8, 0, 0));
    send_request(make_date(2010, 1, 32, 8, 0, 0));
    send_request(make_date(2010, 1, 0, 8, 0, 0));
    send_request(make_date(2010, 0, 1, 8, 0, 0));
    send_request(make_date(2010, 13, 1, 8, 0, 0));
    send_request(make_date(2006, 12, 31, 8, 0, 0));
    send_request(make_date(2100, 1, 1, 8, 0, 0));
    send_request(make_date(2010, 5, 5, 24, 0, 0));
    send_request(make_date(2010, 5, 5, 0, 60, 0));
    send_request(make_date(2010, 5, 5, 0, 0, 60));
    send_request(make_date(16383, 127, 127, 127, 127, 127));
    send_request(make_date(0, 0, 0, 0, 0, 0));
    send_request(make_date(2010, 5, 127, 23, 59, 59));

    // Random: mostly valid dates, mixed with single-field breaks and raw noise.
    for (int unsigned i = 0; i < NumRandom; i++) begin
      if ((i < 200 || i >= 350) && $urandom_range(99, 0) < 10) begin
        idle_gap($urandom_range(4, 1));
      end
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        r = random_valid_date();
      end else if (pick < 85) begin
        r = random_broken_date();
      end else begin
        r = make_date($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send_request(r);
    end
    start_i <= 1'b0;

    // Drain the outstanding results, then let the pipeline settle.
    while (dates.expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (dates.errors == 0 && dates.expected_dates.size() == 0) begin
      $display("tb_date_time_check_and_weekday OK");
    end else begin
      $display("tb_date_time_check_and_weekday NOT OK");
    end
    $finish;
  end

endmodule
